>>> hdl/lkr_pkg.sv
// Shared types and constants for the LRU-K replacement unit.
`timescale 1ns / 1ps

package lkr_pkg;

  // Default geometry
  localparam int NUM_SLOTS_DEF = 64;
  localparam int HISTORY_K_DEF = 2;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int SLOT_W = 6;
  localparam int KIND_W = 2;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER   = 2'd0,
    KIND_ACCESS     = 2'd1,
    KIND_EVICT_MARK = 2'd2,
    KIND_VICTIM     = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_UPDATE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SHIFT_LAST,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the victim compare unit
  typedef struct packed {
    logic clear;       // start of a victim scan
    logic sample;      // a slot is presented this cycle
    logic live;        // slot is registered and evictable
    logic unused;      // slot has no accesses
    logic short_hist;  // slot has fewer than K accesses
  } pick_ctl_t;

endpackage

>>> hdl/lkr_pick.sv
// Victim compare unit: one shared timestamp comparator and the running best candidates.
`timescale 1ns / 1ps

module lkr_pick #(
  parameter int NUM_SLOTS = lkr_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = lkr_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lkr_pkg::pick_ctl_t                    ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]          slot,
  input  logic [TIME_BITS-1:0]                  stamp,
  output logic                                  found,
  output logic [$clog2(NUM_SLOTS)-1:0]          victim
);
  import lkr_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  logic                 short_found;
  logic                 short_unused;
  logic                 full_found;
  logic [SW-1:0]        short_slot;
  logic [SW-1:0]        full_slot;
  logic [TIME_BITS-1:0] short_time;
  logic [TIME_BITS-1:0] full_time;

  logic [TIME_BITS-1:0] cur_time;
  logic                 older;
  logic                 take_unused;
  logic                 take_short;
  logic                 take_full;

  // Single comparator, shared between the short and full history classes
  assign cur_time = ctl.short_hist ? short_time : full_time;
  assign older    = stamp < cur_time;

  always_comb begin
    take_unused = 1'b0;
    take_short  = 1'b0;
    take_full   = 1'b0;
    if (ctl.sample && ctl.live) begin
      if (ctl.unused) begin
        take_unused = !short_unused;
      end else if (ctl.short_hist) begin
        take_short = !short_unused && (!short_found || older);
      end else begin
        take_full = !full_found || older;
      end
    end
  end

  // Candidate flags
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      short_found  <= 1'b0;
      short_unused <= 1'b0;
      full_found   <= 1'b0;
    end else begin
      if (take_unused) begin
        short_unused <= 1'b1;
        short_found  <= 1'b1;
      end
      if (take_short) begin
        short_found <= 1'b1;
      end
      if (take_full) begin
        full_found <= 1'b1;
      end
    end
  end

  // Candidate payload
  always_ff @(posedge clk) begin
    if (take_unused || take_short) begin
      short_slot <= slot;
      short_time <= stamp;
    end
    if (take_full) begin
      full_slot <= slot;
      full_time <= stamp;
    end
  end

  // Short-history candidates win over full-history ones
  always_comb begin
    found  = short_found || full_found;
    victim = '0;
    if (short_found) begin
      victim = short_slot;
    end else if (full_found) begin
      victim = full_slot;
    end
  end

endmodule

>>> hdl/lkr_core.sv
// Sequencer, slot state memory, timestamp memory and global time.
`timescale 1ns / 1ps

module lkr_core #(
  parameter int NUM_SLOTS = lkr_pkg::NUM_SLOTS_DEF,
  parameter int HISTORY_K = lkr_pkg::HISTORY_K_DEF,
  parameter int TIME_BITS = lkr_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lkr_pkg::kind_t              in_kind,
  input  logic [lkr_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        in_flag,
  input  logic                        out_free,
  output logic                        res_valid,
  output logic                        res_found,
  output logic [lkr_pkg::SLOT_W-1:0]  res_slot
);
  import lkr_pkg::*;

  localparam int SW    = $clog2(NUM_SLOTS);
  localparam int CW    = $clog2(HISTORY_K + 1);
  localparam int KW    = (HISTORY_K > 1) ? $clog2(HISTORY_K) : 1;
  localparam int MW    = CW + 2;
  localparam int AW    = SW + KW;
  localparam int CMPW  = ((SW > SLOT_W) ? SW : SLOT_W) + 1;
  localparam int DEPTH = NUM_SLOTS << KW;

  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(HISTORY_K);

  state_t state, state_next;

  // Latched command
  kind_t             cmd_kind;
  logic [SLOT_W-1:0] cmd_slot;
  logic              cmd_flag;
  logic [SW-1:0]     cmd_addr;
  logic              cmd_in_range;

  logic [SW-1:0]        scan_addr;
  logic [KW-1:0]        shf_idx;
  logic [TIME_BITS-1:0] gtime;
  logic                 time_inc;
  logic                 scan_issue;
  logic                 scan_clear;

  // Scan pipeline
  logic          p1_valid;
  logic [SW-1:0] p1_slot;
  logic          p2_valid;
  logic [SW-1:0] p2_slot;
  logic [MW-1:0] p2_meta;

  // Slot state memory: {registered, evictable, count}
  logic [MW-1:0] meta_mem [NUM_SLOTS];
  logic [MW-1:0] meta_rdata;
  logic          meta_we;
  logic [SW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic [SW-1:0] meta_raddr;

  // Timestamp memory, addressed {slot, index}, oldest stamp at index 0
  logic [TIME_BITS-1:0] stamp_mem [DEPTH];
  logic [TIME_BITS-1:0] stamp_rdata;
  logic                 stamp_we;
  logic [AW-1:0]        stamp_waddr;
  logic [TIME_BITS-1:0] stamp_wdata;
  logic [AW-1:0]        stamp_raddr;

  logic          m_reg;
  logic          m_ev;
  logic [CW-1:0] m_cnt;
  logic          m_full;
  logic [KW-1:0] scan_idx;
  logic [CW-1:0] p2_cnt;

  pick_ctl_t               pick_ctl;
  logic [SW-1:0]           pick_victim;

  assign cmd_addr     = SW'(cmd_slot);
  assign cmd_in_range = CMPW'(cmd_slot) < CMPW'(NUM_SLOTS);

  assign m_reg  = meta_rdata[MW-1];
  assign m_ev   = meta_rdata[MW-2];
  assign m_cnt  = meta_rdata[CW-1:0];
  assign m_full = m_cnt == CNT_FULL;

  // Stamp that ranks a slot: K-th most recent when full, else the latest
  assign scan_idx = m_full ? '0 : KW'(m_cnt - CW'(1));

  assign in_ready = state == ST_IDLE;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (scan_addr == LAST_SLOT) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_META;
      end
      ST_META: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
        if (cmd_kind == KIND_VICTIM) begin
          state_next = ST_SCAN;
        end else if (cmd_kind == KIND_ACCESS && cmd_in_range && m_reg && m_full) begin
          state_next = (HISTORY_K == 1) ? ST_SHIFT_LAST : ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        if (shf_idx == KW'(HISTORY_K - 2)) state_next = ST_SHIFT_LAST;
        else state_next = ST_SHIFT_RD;
      end
      ST_SHIFT_LAST: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_addr == LAST_SLOT) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_valid && !p2_valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory and unit controls
  always_comb begin
    meta_we     = 1'b0;
    meta_waddr  = cmd_addr;
    meta_wdata  = '0;
    stamp_we    = 1'b0;
    stamp_waddr = {cmd_addr, shf_idx};
    stamp_wdata = gtime;
    time_inc    = 1'b0;
    scan_issue  = 1'b0;
    scan_clear  = 1'b0;
    res_valid   = 1'b0;
    case (state)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = scan_addr;
      end
      ST_UPDATE: begin
        case (cmd_kind)
          KIND_REGISTER: begin
            meta_we    = cmd_in_range;
            meta_wdata = {1'b1, 1'b0, {CW{1'b0}}};
          end
          KIND_ACCESS: begin
            if (cmd_in_range && m_reg && !m_full) begin
              stamp_we    = 1'b1;
              stamp_waddr = {cmd_addr, KW'(m_cnt)};
              meta_we     = 1'b1;
              meta_wdata  = {m_reg, m_ev, CW'(m_cnt + CW'(1))};
              time_inc    = 1'b1;
            end
          end
          KIND_EVICT_MARK: begin
            meta_we    = cmd_in_range && m_reg;
            meta_wdata = {1'b1, cmd_flag, m_cnt};
          end
          KIND_VICTIM: begin
            scan_clear = 1'b1;
          end
          default: begin
            scan_clear = 1'b0;
          end
        endcase
      end
      ST_SHIFT_WR: begin
        stamp_we    = 1'b1;
        stamp_wdata = stamp_rdata;
      end
      ST_SHIFT_LAST: begin
        stamp_we    = 1'b1;
        stamp_waddr = {cmd_addr, KW'(HISTORY_K - 1)};
        time_inc    = 1'b1;
      end
      ST_SCAN: begin
        scan_issue = 1'b1;
      end
      ST_DONE: begin
        res_valid = out_free;
      end
      default: begin
        scan_issue = 1'b0;
      end
    endcase
  end

  // Read address selection
  assign meta_raddr  = (state == ST_SCAN) ? scan_addr : cmd_addr;
  assign stamp_raddr = (state == ST_SHIFT_RD) ? {cmd_addr, KW'(shf_idx + KW'(1))}
                                              : {p1_slot, scan_idx};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counter for clearing and scanning
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (state == ST_CLEAR || state == ST_SCAN) begin
      scan_addr <= (scan_addr == LAST_SLOT) ? '0 : scan_addr + SW'(1);
    end
  end

  // History shift index
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      shf_idx <= '0;
    end else if (state == ST_SHIFT_WR) begin
      shf_idx <= shf_idx + KW'(1);
    end
  end

  // Global time, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      gtime <= '0;
    end else if (time_inc && gtime != '1) begin
      gtime <= gtime + TIME_BITS'(1);
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_kind <= in_kind;
      cmd_slot <= in_slot;
      cmd_flag <= in_flag;
    end
  end

  // Scan pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= scan_issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_slot <= scan_addr;
    p2_slot <= p1_slot;
    p2_meta <= meta_rdata;
  end

  // Slot state memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_raddr];
  end

  // Timestamp memory
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    stamp_rdata <= stamp_mem[stamp_raddr];
  end

  // Victim compare unit
  assign p2_cnt = p2_meta[CW-1:0];

  always_comb begin
    pick_ctl.clear      = scan_clear;
    pick_ctl.sample     = p2_valid;
    pick_ctl.live       = p2_meta[MW-1] && p2_meta[MW-2];
    pick_ctl.unused     = p2_cnt == '0;
    pick_ctl.short_hist = p2_cnt != CNT_FULL;
  end

  lkr_pick #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk    (clk),
    .rst    (rst),
    .ctl    (pick_ctl),
    .slot   (p2_slot),
    .stamp  (stamp_rdata),
    .found  (res_found),
    .victim (pick_victim)
  );

  assign res_slot = SLOT_W'(pick_victim);

`ifndef NO_ASSERTIONS
  // No scan in flight while a new item can be taken
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!p1_valid && !p2_valid))
    else $error("scan pipeline busy while ready");

  // Second scan stage only follows the first
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> $past(p1_valid))
    else $error("scan stage 2 without stage 1");

  // Scanning feeds the pipeline on the next cycle
  a_scan_feeds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> p1_valid)
    else $error("scan read not tracked");

  // Time only holds or steps by one
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    (gtime == $past(gtime)) || (gtime == $past(gtime) + TIME_BITS'(1)))
    else $error("global time jumped");
`endif

endmodule

>>> hdl/lru_k_replacer_unit.sv
// Top level of the LRU-K victim selector with its result register.
//
//  channel | dir | tdata                              | tuser
//  --------+-----+------------------------------------+------------------
//  s_      | in  | [5:0] slot, [6] evictable_flag     | [1:0] kind
//  m_      | out | [5:0] victim_slot                  | [0] victim_found
//
// Register, access and mark items pass through the META and UPDATE states; an access to a slot
// with a full history then moves each older stamp down (SHIFT_RD, SHIFT_WR) and writes the new
// stamp in SHIFT_LAST. A victim request scans one slot per cycle through the single read port
// of the slot state memory.
// After reset a pass over every slot clears the slot state memory; s_tready is low meanwhile.
// Only victim requests make a result; the block waits at the end of a scan
// only while the previous result is still held in the output register.
`timescale 1ns / 1ps

module lru_k_replacer_unit #(
  parameter int NUM_SLOTS = lkr_pkg::NUM_SLOTS_DEF,
  parameter int HISTORY_K = lkr_pkg::HISTORY_K_DEF,
  parameter int TIME_BITS = lkr_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [5:0] slot, [6] evictable_flag, [7] zero
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] victim_slot, [7:6] zero
  output logic [0:0] m_tuser    // [0] victim_found
);
  import lkr_pkg::*;

  logic              out_free;
  logic              res_valid;
  logic              res_found;
  logic [SLOT_W-1:0] res_slot;

  assign out_free = !m_tvalid || m_tready;

  lkr_core #(
    .NUM_SLOTS (NUM_SLOTS),
    .HISTORY_K (HISTORY_K),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (kind_t'(s_tuser)),
    .in_slot   (s_tdata[SLOT_W-1:0]),
    .in_flag   (s_tdata[SLOT_W]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_found (res_found),
    .res_slot  (res_slot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {2'b00, res_slot};
      m_tuser <= res_found;
    end
  end

endmodule
